@@ rtl/core/csb_pkg.sv @@
// shared constants, types and helper functions of the circle segment bounce unit
package csb_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int RAD_W  = 31;
  localparam int VEL_W  = 32;
  localparam int BNC_W  = 18;
  localparam int QUO_W  = 32;
  localparam int LIMB_W = 32;
  localparam int FRAC_W = 16;

  // divider: one setup stage, one stage per quotient bit, one saturation stage
  localparam int DIV_LAT = QUO_W + 2;

  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SEG_START_X  = 3'd0,
    REG_SEG_START_Y  = 3'd1,
    REG_SEG_END_X    = 3'd2,
    REG_SEG_END_Y    = 3'd3,
    REG_SEG_BOUNCE_X = 3'd4,
    REG_SEG_BOUNCE_Y = 3'd5
  } csb_reg_e;

  localparam int SEG_END_X_RST = 65536;
  localparam int SEG_BNC_RST   = 65536;

  localparam logic [QUO_W-1:0] SAT_MAX = {1'b0, {(QUO_W-1){1'b1}}};
  localparam logic [QUO_W-1:0] SAT_MIN = {1'b1, {(QUO_W-1){1'b0}}};

  typedef struct packed {
    logic neg;   // quotient is negated
    logic keep;  // result is kept, else forced to zero
  } csb_div_ctl_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // register stages of the limb multiplier: product stage plus adder tree levels
  function automatic int mul_lat(input int aw, input int bw);
    int na;
    int nb;
    na = (aw + LIMB_W - 1) / LIMB_W;
    nb = (bw + LIMB_W - 1) / LIMB_W;
    return 1 + $clog2(na * nb);
  endfunction

endpackage

@@ rtl/core/circle_segment_bounce_unit.sv @@
// circle against line segment collision test with bounce velocity change
//
// one circle request enters per cycle while the pipeline is not stalled, and
// one result leaves per request, in order. the bulk of the pipeline is the
// 34-stage restoring divider (one quotient bit per stage) and the registered
// adder trees of the 32-bit limb multipliers. the whole pipeline advances
// together: it moves whenever the output register is empty or taken, so
// s_axis_tready drops only while a finished result waits on the master
// side. the segment registers are read directly by the first stage and are
// to be written while no request is in flight. hit is set when the squared
// distance from the center to the clamped closest point is below the
// squared radius; dvel is the exact -2*n*(v.n)*ball_bounce*seg_bounce per
// axis, truncated toward zero and saturated to signed 32 bits, and zero
// without a hit, for a zero-length segment or with the center exactly on
// the segment.
module circle_segment_bounce_unit #(
  parameter int COORD_WIDTH = csb_pkg::COORD_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // center_x, center_y, radius, vel_x, vel_y, ball_bounce_x, ball_bounce_y
  input  logic [((2*COORD_WIDTH+2*csb_pkg::VEL_W+csb_pkg::RAD_W+2*csb_pkg::BNC_W+7)/8)*8-1:0]
               s_axis_tdata,

  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // hit, dvel_x, dvel_y
  output logic [((1+2*csb_pkg::QUO_W+7)/8)*8-1:0] m_axis_tdata,

  input  logic                          cfg_we_i,
  input  logic [csb_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [csb_pkg::max_int(COORD_WIDTH, csb_pkg::BNC_W)-1:0] cfg_wdata_i
);
  import csb_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;             // coordinate differences
  localparam int QW    = 2 * DW + 1;         // squared lengths and dot products
  localparam int R2W   = 2 * (RAD_W + 1);    // squared radius
  localparam int VW    = VEL_W + DW + 1;     // v . m
  localparam int SW    = DW + VW;            // m_a * (v . m)
  localparam int KW    = 2 * BNC_W;          // bounce product
  localparam int HAW   = SW + 1;
  localparam int HBW   = KW + 1;
  localparam int HPW   = HAW + HBW;
  localparam int NSH   = 2 * FRAC_W - 1;     // factor two folded into the 2^32 scale
  localparam int NW    = HPW - NSH;
  localparam int XW    = max_int(QW, R2W);
  localparam int YW    = max_int(2 * QW, R2W + QW);
  localparam int OUT_B = 1 + 2 * QUO_W;
  localparam int OUT_W = ((OUT_B + 7) / 8) * 8;

  localparam int LA  = mul_lat(DW, DW);
  localparam int LR  = mul_lat(VEL_W, VEL_W);
  localparam int LD1 = mul_lat(QW, QW);
  localparam int LD2 = mul_lat(R2W, QW);
  localparam int LD3 = mul_lat(VEL_W, DW);
  localparam int LD  = max_int(LD1, max_int(LD2, LD3));
  localparam int LF  = mul_lat(DW, VW);
  localparam int LH  = mul_lat(HAW, HBW);
  localparam int TOT = 1 + LA + 1 + 1 + LD + 1 + LF + 1 + LH + DIV_LAT;
  localparam int EI  = LA + LD + 3;          // valid index of the hit/move stage

  // ---------------------------------------------------------------- config
  logic signed [CW-1:0]    seg_sx_q, seg_sy_q, seg_ex_q, seg_ey_q;
  logic        [BNC_W-1:0] seg_bx_q, seg_by_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_sx_q <= '0;
      seg_sy_q <= '0;
      seg_ex_q <= CW'(SEG_END_X_RST);
      seg_ey_q <= '0;
      seg_bx_q <= BNC_W'(SEG_BNC_RST);
      seg_by_q <= BNC_W'(SEG_BNC_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SEG_START_X:  seg_sx_q <= cfg_wdata_i[CW-1:0];
        REG_SEG_START_Y:  seg_sy_q <= cfg_wdata_i[CW-1:0];
        REG_SEG_END_X:    seg_ex_q <= cfg_wdata_i[CW-1:0];
        REG_SEG_END_Y:    seg_ey_q <= cfg_wdata_i[CW-1:0];
        REG_SEG_BOUNCE_X: seg_bx_q <= cfg_wdata_i[BNC_W-1:0];
        REG_SEG_BOUNCE_Y: seg_by_q <= cfg_wdata_i[BNC_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- flow control
  // single enable for the whole pipe; a stall freezes every stage
  logic            en;
  logic [TOT-1:0]  valid_q;

  assign en            = !valid_q[TOT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = valid_q[TOT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[TOT-2:0], s_axis_tvalid};
    end
  end

  // ------------------------------------------- stage 0: differences, bounce
  logic signed [CW-1:0]    in_cx, in_cy;
  logic        [RAD_W-1:0] in_rad;
  logic signed [VEL_W-1:0] in_vx, in_vy;
  logic        [BNC_W-1:0] in_bx, in_by;

  assign in_cx  = s_axis_tdata[0 +: CW];
  assign in_cy  = s_axis_tdata[CW +: CW];
  assign in_rad = s_axis_tdata[2*CW +: RAD_W];
  assign in_vx  = s_axis_tdata[2*CW+RAD_W +: VEL_W];
  assign in_vy  = s_axis_tdata[2*CW+RAD_W+VEL_W +: VEL_W];
  assign in_bx  = s_axis_tdata[2*CW+RAD_W+2*VEL_W +: BNC_W];
  assign in_by  = s_axis_tdata[2*CW+RAD_W+2*VEL_W+BNC_W +: BNC_W];

  typedef struct packed {
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic        [KW-1:0]    kx;
    logic        [KW-1:0]    ky;
    logic signed [DW-1:0]    dx;
    logic signed [DW-1:0]    dy;
    logic signed [DW-1:0]    wx;
    logic signed [DW-1:0]    wy;
    logic signed [DW-1:0]    ux;
    logic signed [DW-1:0]    uy;
  } geo_t;

  geo_t             a_geo_q;
  logic [RAD_W-1:0] a_rad_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // d: segment direction, w: from start, u: from end
      a_geo_q.dx <= DW'(seg_ex_q) - DW'(seg_sx_q);
      a_geo_q.dy <= DW'(seg_ey_q) - DW'(seg_sy_q);
      a_geo_q.wx <= DW'(in_cx) - DW'(seg_sx_q);
      a_geo_q.wy <= DW'(in_cy) - DW'(seg_sy_q);
      a_geo_q.ux <= DW'(in_cx) - DW'(seg_ex_q);
      a_geo_q.uy <= DW'(in_cy) - DW'(seg_ey_q);
      a_geo_q.vx <= in_vx;
      a_geo_q.vy <= in_vy;
      a_geo_q.kx <= KW'(in_bx) * KW'(seg_bx_q);
      a_geo_q.ky <= KW'(in_by) * KW'(seg_by_q);
      a_rad_q    <= in_rad;
    end
  end

  // ------------------------------------------------ section a: squares
  logic signed [2*DW-1:0]  p_dxdx, p_dydy, p_wxdx, p_wydy, p_dxwy, p_dywx;
  logic signed [2*DW-1:0]  p_uxux, p_uyuy, p_wxwx, p_wywy;
  logic signed [R2W-1:0]   p_r2, p_r2_al;
  geo_t                    a_geo_al;

  csb_mul #(.AW(DW), .BW(DW)) u_mul_dxdx (.clk_i, .en_i(en),
    .a_i(a_geo_q.dx), .b_i(a_geo_q.dx), .p_o(p_dxdx));
  csb_mul #(.AW(DW), .BW(DW)) u_mul_dydy (.clk_i, .en_i(en),
    .a_i(a_geo_q.dy), .b_i(a_geo_q.dy), .p_o(p_dydy));
  csb_mul #(.AW(DW), .BW(DW)) u_mul_wxdx (.clk_i, .en_i(en),
    .a_i(a_geo_q.wx), .b_i(a_geo_q.dx), .p_o(p_wxdx));
  csb_mul #(.AW(DW), .BW(DW)) u_mul_wydy (.clk_i, .en_i(en),
    .a_i(a_geo_q.wy), .b_i(a_geo_q.dy), .p_o(p_wydy));
  csb_mul #(.AW(DW), .BW(DW)) u_mul_dxwy (.clk_i, .en_i(en),
    .a_i(a_geo_q.dx), .b_i(a_geo_q.wy), .p_o(p_dxwy));
  csb_mul #(.AW(DW), .BW(DW)) u_mul_dywx (.clk_i, .en_i(en),
    .a_i(a_geo_q.dy), .b_i(a_geo_q.wx), .p_o(p_dywx));
  csb_mul #(.AW(DW), .BW(DW)) u_mul_uxux (.clk_i, .en_i(en),
    .a_i(a_geo_q.ux), .b_i(a_geo_q.ux), .p_o(p_uxux));
  csb_mul #(.AW(DW), .BW(DW)) u_mul_uyuy (.clk_i, .en_i(en),
    .a_i(a_geo_q.uy), .b_i(a_geo_q.uy), .p_o(p_uyuy));
  csb_mul #(.AW(DW), .BW(DW)) u_mul_wxwx (.clk_i, .en_i(en),
    .a_i(a_geo_q.wx), .b_i(a_geo_q.wx), .p_o(p_wxwx));
  csb_mul #(.AW(DW), .BW(DW)) u_mul_wywy (.clk_i, .en_i(en),
    .a_i(a_geo_q.wy), .b_i(a_geo_q.wy), .p_o(p_wywy));
  csb_mul #(.AW(VEL_W), .BW(VEL_W)) u_mul_r2 (.clk_i, .en_i(en),
    .a_i($signed({1'b0, a_rad_q})), .b_i($signed({1'b0, a_rad_q})), .p_o(p_r2));

  csb_pipe #(.W(R2W), .D(LA - LR)) u_pipe_r2 (.clk_i, .en_i(en),
    .d_i(p_r2), .q_o(p_r2_al));
  csb_pipe #(.W($bits(geo_t)), .D(LA)) u_pipe_a (.clk_i, .en_i(en),
    .d_i(a_geo_q), .q_o(a_geo_al));

  // ---------------------------------------------------- stage b: sums
  logic signed [QW-1:0]  b_len2_q, b_tnum_q, b_cr_q, b_mms_q, b_mme_q;
  logic signed [R2W-1:0] b_r2_q;
  geo_t                  b_geo_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_len2_q <= QW'(p_dxdx) + QW'(p_dydy);
      b_tnum_q <= QW'(p_wxdx) + QW'(p_wydy);
      b_cr_q   <= QW'(p_dxwy) - QW'(p_dywx);
      b_mms_q  <= QW'(p_wxwx) + QW'(p_wywy);
      b_mme_q  <= QW'(p_uxux) + QW'(p_uyuy);
      b_r2_q   <= p_r2_al;
      b_geo_q  <= a_geo_al;
    end
  end

  // ------------------------------------- stage c: endpoint or interior
  logic                 len2_zero, t_pos, t_big, at_end, use_end;
  logic signed [QW-1:0] mm_sel;

  assign len2_zero = b_len2_q == '0;
  assign t_pos     = !b_tnum_q[QW-1] && (b_tnum_q != '0);
  assign t_big     = b_tnum_q >= b_len2_q;
  assign at_end    = len2_zero || !t_pos || t_big;   // projection clamped
  assign use_end   = !len2_zero && t_pos;
  assign mm_sel    = use_end ? b_mme_q : b_mms_q;

  typedef struct packed {
    logic                    edge_hit;
    logic                    edge_move;
    logic                    at_end;
    logic                    cr_nz;
    logic signed [DW-1:0]    mx;
    logic signed [DW-1:0]    my;
    logic signed [QW-1:0]    mm;
    logic        [KW-1:0]    kx;
    logic        [KW-1:0]    ky;
  } dir_t;

  dir_t                    c_dir_q;
  logic signed [QW-1:0]    c_cr_q, c_len2_q;
  logic signed [R2W-1:0]   c_r2_q;
  logic signed [VEL_W-1:0] c_vx_q, c_vy_q;
  logic                    edge_hit;

  assign edge_hit = XW'($unsigned(mm_sel)) < XW'($unsigned(b_r2_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_dir_q.edge_hit  <= edge_hit;
      c_dir_q.edge_move <= edge_hit && (mm_sel != '0) && !len2_zero;
      c_dir_q.at_end    <= at_end;
      c_dir_q.cr_nz     <= b_cr_q != '0;
      // normal direction: toward the center from the clamped point,
      // or the perpendicular of the segment in the interior
      c_dir_q.mx <= at_end ? (use_end ? b_geo_q.ux : b_geo_q.wx) : DW'(-b_geo_q.dy);
      c_dir_q.my <= at_end ? (use_end ? b_geo_q.uy : b_geo_q.wy) : b_geo_q.dx;
      c_dir_q.mm <= at_end ? mm_sel : b_len2_q;
      c_dir_q.kx <= b_geo_q.kx;
      c_dir_q.ky <= b_geo_q.ky;
      c_cr_q     <= b_cr_q;
      c_len2_q   <= b_len2_q;
      c_r2_q     <= b_r2_q;
      c_vx_q     <= b_geo_q.vx;
      c_vy_q     <= b_geo_q.vy;
    end
  end

  // --------------------------------- section d: interior test, v . m
  logic signed [2*QW-1:0]     p_cr2, p_cr2_al;
  logic signed [R2W+QW-1:0]   p_rl, p_rl_al;
  logic signed [VEL_W+DW-1:0] p_vxmx, p_vymy, p_vxmx_al, p_vymy_al;
  dir_t                       d_dir_al;

  csb_mul #(.AW(QW), .BW(QW)) u_mul_cr2 (.clk_i, .en_i(en),
    .a_i(c_cr_q), .b_i(c_cr_q), .p_o(p_cr2));
  csb_mul #(.AW(R2W), .BW(QW)) u_mul_rl (.clk_i, .en_i(en),
    .a_i(c_r2_q), .b_i(c_len2_q), .p_o(p_rl));
  csb_mul #(.AW(VEL_W), .BW(DW)) u_mul_vxmx (.clk_i, .en_i(en),
    .a_i(c_vx_q), .b_i(c_dir_q.mx), .p_o(p_vxmx));
  csb_mul #(.AW(VEL_W), .BW(DW)) u_mul_vymy (.clk_i, .en_i(en),
    .a_i(c_vy_q), .b_i(c_dir_q.my), .p_o(p_vymy));

  csb_pipe #(.W(2*QW), .D(LD - LD1)) u_pipe_cr2 (.clk_i, .en_i(en),
    .d_i(p_cr2), .q_o(p_cr2_al));
  csb_pipe #(.W(R2W+QW), .D(LD - LD2)) u_pipe_rl (.clk_i, .en_i(en),
    .d_i(p_rl), .q_o(p_rl_al));
  csb_pipe #(.W(VEL_W+DW), .D(LD - LD3)) u_pipe_vxmx (.clk_i, .en_i(en),
    .d_i(p_vxmx), .q_o(p_vxmx_al));
  csb_pipe #(.W(VEL_W+DW), .D(LD - LD3)) u_pipe_vymy (.clk_i, .en_i(en),
    .d_i(p_vymy), .q_o(p_vymy_al));
  csb_pipe #(.W($bits(dir_t)), .D(LD)) u_pipe_d (.clk_i, .en_i(en),
    .d_i(c_dir_q), .q_o(d_dir_al));

  // ------------------------------------------------ stage e: hit, move
  logic                 mid_hit;
  logic                 e_hit_q, e_move_q;
  logic signed [VW-1:0] e_vdm_q;
  dir_t                 e_dir_q;

  assign mid_hit = YW'(p_cr2_al) < YW'(p_rl_al);

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_hit_q  <= d_dir_al.at_end ? d_dir_al.edge_hit : mid_hit;
      e_move_q <= d_dir_al.at_end ? d_dir_al.edge_move : (mid_hit && d_dir_al.cr_nz);
      e_vdm_q  <= VW'(p_vxmx_al) + VW'(p_vymy_al);
      e_dir_q  <= d_dir_al;
    end
  end

  // ------------------------------------------ section f: m_a * (v . m)
  typedef struct packed {
    logic                 hit;
    logic                 move;
    logic signed [QW-1:0] mm;
    logic        [KW-1:0] kx;
    logic        [KW-1:0] ky;
  } fin_t;

  logic signed [SW-1:0] p_sx, p_sy;
  fin_t                 f_fin, f_fin_al;

  assign f_fin = '{hit: e_hit_q, move: e_move_q, mm: e_dir_q.mm,
                   kx: e_dir_q.kx, ky: e_dir_q.ky};

  csb_mul #(.AW(DW), .BW(VW)) u_mul_sx (.clk_i, .en_i(en),
    .a_i(e_dir_q.mx), .b_i(e_vdm_q), .p_o(p_sx));
  csb_mul #(.AW(DW), .BW(VW)) u_mul_sy (.clk_i, .en_i(en),
    .a_i(e_dir_q.my), .b_i(e_vdm_q), .p_o(p_sy));
  csb_pipe #(.W($bits(fin_t)), .D(LF)) u_pipe_f (.clk_i, .en_i(en),
    .d_i(f_fin), .q_o(f_fin_al));

  // --------------------------------------------- stage g: magnitude, sign
  logic [SW-1:0] g_magx_q, g_magy_q;
  logic          g_negx_q, g_negy_q;
  fin_t          g_fin_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // the factor -2 flips the sign
      g_magx_q <= p_sx[SW-1] ? SW'(-p_sx) : p_sx;
      g_magy_q <= p_sy[SW-1] ? SW'(-p_sy) : p_sy;
      g_negx_q <= !p_sx[SW-1];
      g_negy_q <= !p_sy[SW-1];
      g_fin_q  <= f_fin_al;
    end
  end

  // -------------------------------------------- section h: times bounce
  typedef struct packed {
    logic                 hit;
    logic                 move;
    logic                 negx;
    logic                 negy;
    logic signed [QW-1:0] mm;
  } div_side_t;

  logic signed [HPW-1:0] p_nx, p_ny;
  div_side_t             h_side, h_side_al;

  assign h_side = '{hit: g_fin_q.hit, move: g_fin_q.move, negx: g_negx_q,
                    negy: g_negy_q, mm: g_fin_q.mm};

  csb_mul #(.AW(HAW), .BW(HBW)) u_mul_nx (.clk_i, .en_i(en),
    .a_i($signed({1'b0, g_magx_q})), .b_i($signed({1'b0, g_fin_q.kx})), .p_o(p_nx));
  csb_mul #(.AW(HAW), .BW(HBW)) u_mul_ny (.clk_i, .en_i(en),
    .a_i($signed({1'b0, g_magy_q})), .b_i($signed({1'b0, g_fin_q.ky})), .p_o(p_ny));
  csb_pipe #(.W($bits(div_side_t)), .D(LH)) u_pipe_h (.clk_i, .en_i(en),
    .d_i(h_side), .q_o(h_side_al));

  // ------------------------------------------------ division by |m|^2
  csb_div_ctl_t     ctl_x, ctl_y;
  logic [QUO_W-1:0] dvel_x, dvel_y;
  logic             hit_out;

  assign ctl_x = '{neg: h_side_al.negx, keep: h_side_al.move};
  assign ctl_y = '{neg: h_side_al.negy, keep: h_side_al.move};

  csb_div #(.NW(NW), .QW(QW)) u_div_x (.clk_i, .en_i(en),
    .num_i(p_nx[HPW-1:NSH]), .den_i($unsigned(h_side_al.mm)), .ctl_i(ctl_x),
    .quo_o(dvel_x));
  csb_div #(.NW(NW), .QW(QW)) u_div_y (.clk_i, .en_i(en),
    .num_i(p_ny[HPW-1:NSH]), .den_i($unsigned(h_side_al.mm)), .ctl_i(ctl_y),
    .quo_o(dvel_y));
  csb_pipe #(.W(1), .D(DIV_LAT)) u_pipe_hit (.clk_i, .en_i(en),
    .d_i(h_side_al.hit), .q_o(hit_out));

  assign m_axis_tdata = {{(OUT_W-OUT_B){1'b0}}, dvel_y, dvel_x, hit_out};

`ifndef SYNTHESIS
  // a miss never moves the circle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (dvel_x == '0 && dvel_y == '0))
    else $error("velocity change without a hit");

  // movement is only granted on a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[EI] && e_move_q) |-> e_hit_q)
    else $error("move flag set without hit");

  // a stall freezes the valid chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> (valid_q == $past(valid_q)))
    else $error("pipeline moved during stall");
`endif

endmodule

@@ rtl/core/csb_pipe.sv @@
// delay line with stall enable for pipeline side data
module csb_pipe #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  if (D == 0) begin : g_none
    assign q_o = d_i;
  end else begin : g_dly
    logic [W-1:0] sr_q [D];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sr_q[0] <= d_i;
        for (int i = 1; i < D; i++) begin
          sr_q[i] <= sr_q[i-1];
        end
      end
    end

    assign q_o = sr_q[D-1];
  end

endmodule

@@ rtl/core/csb_mul.sv @@
// pipelined signed multiplier: limb partial products and a registered adder tree
module csb_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0] p_o
);
  import csb_pkg::*;

  localparam int NA  = (AW + LIMB_W - 1) / LIMB_W;
  localparam int NB  = (BW + LIMB_W - 1) / LIMB_W;
  localparam int NP  = NA * NB;
  localparam int LV  = $clog2(NP);
  localparam int NL  = 1 << LV;
  localparam int NN  = 2 * NL - 1;
  localparam int PW  = AW + BW;
  localparam int AEW = NA * LIMB_W;
  localparam int BEW = NB * LIMB_W;

  logic signed [AEW-1:0] a_ext;
  logic signed [BEW-1:0] b_ext;
  logic signed [PW-1:0]  node_q [NN];

  assign a_ext = AEW'(a_i);
  assign b_ext = BEW'(b_i);

  for (genvar l = 0; l < NL; l++) begin : g_leaf
    if (l < NP) begin : g_pp
      localparam int I = l / NB;
      localparam int J = l % NB;
      logic signed [LIMB_W:0]     la;
      logic signed [LIMB_W:0]     lb;
      logic signed [2*LIMB_W+1:0] pp;

      // top limb carries the sign, lower limbs are unsigned
      assign la = {(I == NA-1) ? a_ext[AEW-1] : 1'b0, a_ext[I*LIMB_W +: LIMB_W]};
      assign lb = {(J == NB-1) ? b_ext[BEW-1] : 1'b0, b_ext[J*LIMB_W +: LIMB_W]};
      assign pp = la * lb;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          node_q[NL-1+l] <= PW'(pp) <<< (LIMB_W * (I + J));
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          node_q[NL-1+l] <= '0;
        end
      end
    end
  end

  for (genvar n = 0; n < NL - 1; n++) begin : g_sum
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        node_q[n] <= node_q[2*n+1] + node_q[2*n+2];
      end
    end
  end

  assign p_o = node_q[0];

endmodule

@@ rtl/core/csb_div.sv @@
// pipelined restoring divider, 32-bit quotient with signed saturation
module csb_div #(
  parameter int NW = 106,
  parameter int QW = 67
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [NW-1:0]              num_i,
  input  logic [QW-1:0]              den_i,
  input  csb_pkg::csb_div_ctl_t      ctl_i,
  output logic [csb_pkg::QUO_W-1:0]  quo_o
);
  import csb_pkg::*;

  localparam int HW = NW - QUO_W;
  localparam int HX = max_int(HW, QW);
  localparam int ST = QUO_W;

  logic [HX-1:0]    hi_x;
  logic [HX-1:0]    den_x;
  logic [QW-1:0]    rem_q [ST+1];
  logic [QW-1:0]    den_q [ST+1];
  logic [QUO_W-1:0] lo_q  [ST];
  logic [QUO_W-1:0] q_q   [ST+1];
  logic             ovf_q [ST+1];
  csb_div_ctl_t     ctl_q [ST+1];
  logic [QW:0]      trial [ST];
  logic             take  [ST];
  logic [QUO_W-1:0] res_d;
  logic [QUO_W-1:0] res_q;

  assign hi_x  = HX'(num_i[NW-1:QUO_W]);
  assign den_x = HX'(den_i);

  always_comb begin
    for (int k = 0; k < ST; k++) begin
      trial[k] = {rem_q[k], lo_q[k][QUO_W-1]};
      take[k]  = trial[k] >= {1'b0, den_q[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // quotient overflows 32 bits when the high part already reaches the divisor
      rem_q[0] <= QW'(hi_x);
      lo_q[0]  <= num_i[QUO_W-1:0];
      q_q[0]   <= '0;
      ovf_q[0] <= hi_x >= den_x;
      den_q[0] <= den_i;
      ctl_q[0] <= ctl_i;
      for (int k = 0; k < ST; k++) begin
        rem_q[k+1] <= take[k] ? QW'(trial[k] - {1'b0, den_q[k]}) : QW'(trial[k]);
        q_q[k+1]   <= {q_q[k][QUO_W-2:0], take[k]};
        ovf_q[k+1] <= ovf_q[k];
        den_q[k+1] <= den_q[k];
        ctl_q[k+1] <= ctl_q[k];
      end
      for (int k = 0; k < ST - 1; k++) begin
        lo_q[k+1] <= lo_q[k] << 1;
      end
      res_q <= res_d;
    end
  end

  always_comb begin
    priority if (!ctl_q[ST].keep) begin
      res_d = '0;
    end else if (ovf_q[ST]) begin
      res_d = ctl_q[ST].neg ? SAT_MIN : SAT_MAX;
    end else if (ctl_q[ST].neg) begin
      res_d = (q_q[ST] > SAT_MIN) ? SAT_MIN : QUO_W'(-q_q[ST]);
    end else begin
      res_d = q_q[ST][QUO_W-1] ? SAT_MAX : q_q[ST];
    end
  end

  assign quo_o = res_q;

endmodule

@@ sim/tb_circle_segment_bounce_unit.sv @@
// testbench for the circle segment bounce unit: random and directed circles, checked in order
module tb_circle_segment_bounce_unit;
  import csb_pkg::*;

  typedef logic signed [255:0] wide_t;

  // one circle request as it travels on the slave side
  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        rad;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [17:0]        bbx;
    logic [17:0]        bby;
  } circle_t;

  // one bounce result as it leaves on the master side
  typedef struct {
    logic               hit;
    logic signed [31:0] dvx;
    logic signed [31:0] dvy;
  } bounce_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // center_x, center_y, radius, vel_x, vel_y, ball_bounce_x, ball_bounce_y
  logic [199:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // hit, dvel_x, dvel_y
  logic [71:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  circle_segment_bounce_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // our copy of the segment registers, reset values as in the block
  logic signed [31:0] seg_sx = 0, seg_sy = 0, seg_ex = 65536, seg_ey = 0;
  logic [17:0]        seg_bx = 65536, seg_by = 65536;

  circle_t pending_circles[$];
  bounce_t expected_bounces[$];
  circle_t cur_circle;
  bit      req_taken;
  int      send_idle_pct;
  int      recv_idle_pct;
  bit      hold_sender;
  int      errors;
  int      cycles;

  // velocity change along one axis: -2*m_a*(v.m)*bb*sb / (|m|^2 * 2^32), saturated
  function automatic logic [31:0] axis_change(wide_t ma, wide_t vdm, wide_t mm,
                                              wide_t bb, wide_t sb);
    wide_t num;
    wide_t den;
    wide_t q;
    wide_t hi;
    num = -2 * ma * vdm * bb * sb;
    den = mm <<< 32;
    q   = num / den;
    hi  = 32'sh7fffffff;
    if (q > hi) return 32'h7fffffff;
    if (q < -hi - 1) return 32'h80000000;
    return q[31:0];
  endfunction

  // closest point on the clamped segment, overlap test and bounce change
  function automatic bounce_t predict_bounce(circle_t c);
    wide_t p1x, p1y, p2x, p2y, cx, cy, rr, vx, vy;
    wide_t dx, dy, wx, wy, len2, r2, tnum, mx, my, mm, cr, vdm;
    bit hit;
    bit move;
    bounce_t r;
    p1x = seg_sx; p1y = seg_sy; p2x = seg_ex; p2y = seg_ey;
    cx = c.cx; cy = c.cy; vx = c.vx; vy = c.vy;
    rr = {1'b0, c.rad};
    dx = p2x - p1x; dy = p2y - p1y;
    wx = cx - p1x;  wy = cy - p1y;
    len2 = dx * dx + dy * dy;
    r2   = rr * rr;
    tnum = wx * dx + wy * dy;
    if (len2 == 0 || tnum <= 0 || tnum >= len2) begin
      // endpoint region, or a degenerate segment
      if (len2 != 0 && tnum > 0) begin
        mx = cx - p2x; my = cy - p2y;
      end else begin
        mx = wx; my = wy;
      end
      mm   = mx * mx + my * my;
      hit  = mm < r2;
      move = hit && mm != 0 && len2 != 0;
    end else begin
      // interior: distance from the cross product
      cr   = dx * wy - dy * wx;
      hit  = cr * cr < r2 * len2;
      move = hit && cr != 0;
      mx = -dy; my = dx; mm = len2;
    end
    r.hit = hit;
    r.dvx = 0;
    r.dvy = 0;
    if (move) begin
      vdm   = vx * mx + vy * my;
      r.dvx = axis_change(mx, vdm, mm, {1'b0, c.bbx}, {1'b0, seg_bx});
      r.dvy = axis_change(my, vdm, mm, {1'b0, c.bby}, {1'b0, seg_by});
    end
    return r;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // request side: a new circle goes out once the previous one was taken; m_axis_tready is also drawn here
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || req_taken) begin
      req_taken = 1'b0;
      if (!hold_sender && pending_circles.size() > 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        cur_circle = pending_circles.pop_front();
        s_axis_tdata <= {5'b0, cur_circle.bby, cur_circle.bbx, cur_circle.vy,
                         cur_circle.vx, cur_circle.rad, cur_circle.cy, cur_circle.cx};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // accepted requests become expectations, accepted results are checked
  always @(posedge clk_i) begin
    bounce_t want;
    if (s_axis_tvalid && s_axis_tready) begin
      expected_bounces.push_back(predict_bounce(cur_circle));
      req_taken = 1'b1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_bounces.size() == 0) begin
        $error("result with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = expected_bounces.pop_front();
        if (m_axis_tdata[0] !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, m_axis_tdata[0]);
          errors++;
        end
        if (m_axis_tdata[32:1] !== want.dvx) begin
          $error("dvel_x: expected %0d, got %0d", want.dvx, $signed(m_axis_tdata[32:1]));
          errors++;
        end
        if (m_axis_tdata[64:33] !== want.dvy) begin
          $error("dvel_y: expected %0d, got %0d", want.dvy, $signed(m_axis_tdata[64:33]));
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("tb_circle_segment_bounce_unit: done, errors");
      $finish;
    end
  end

  // register write, applied to our copy at the same time
  task automatic write_reg(csb_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_SEG_START_X:  seg_sx = val;
      REG_SEG_START_Y:  seg_sy = val;
      REG_SEG_END_X:    seg_ex = val;
      REG_SEG_END_Y:    seg_ey = val;
      REG_SEG_BOUNCE_X: seg_bx = val[17:0];
      REG_SEG_BOUNCE_Y: seg_by = val[17:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                             logic [31:0] ey, logic [31:0] bx, logic [31:0] by);
    write_reg(REG_SEG_START_X, sx);
    write_reg(REG_SEG_START_Y, sy);
    write_reg(REG_SEG_END_X, ex);
    write_reg(REG_SEG_END_Y, ey);
    write_reg(REG_SEG_BOUNCE_X, bx);
    write_reg(REG_SEG_BOUNCE_Y, by);
  endtask

  task automatic wait_drained();
    while (pending_circles.size() > 0 || expected_bounces.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // random circle, mostly placed near a point of the segment so hits are common
  function automatic circle_t random_circle();
    circle_t c;
    longint px, py;
    int sh, k;
    c.cx = $urandom; c.cy = $urandom; c.rad = 31'($urandom);
    c.vx = $urandom; c.vy = $urandom;
    c.bbx = 18'($urandom_range(0, 131072)); c.bby = 18'($urandom_range(0, 131072));
    if ($urandom_range(0, 9) == 0) begin
      c.bbx = 18'($urandom); c.bby = 18'($urandom);
    end
    if ($urandom_range(0, 9) < 7) begin
      k  = $urandom_range(0, 300);
      sh = $urandom_range(2, 26);
      px = longint'(seg_sx) + (longint'(seg_ex) - longint'(seg_sx)) * (k - 20) / 256;
      py = longint'(seg_sy) + (longint'(seg_ey) - longint'(seg_sy)) * (k - 20) / 256;
      c.cx  = 32'(px + ($signed($urandom) >>> (32 - sh)));
      c.cy  = 32'(py + ($signed($urandom) >>> (32 - sh)));
      c.rad = 31'($urandom_range(0, 2 ** sh));
      if ($urandom_range(0, 7) == 0) begin
        // exactly on the segment point
        c.cx = 32'(px); c.cy = 32'(py);
      end
      if ($urandom_range(0, 15) == 0) c.rad = '0;
    end
    return c;
  endfunction

  function automatic circle_t make_circle(logic [31:0] cx, logic [31:0] cy, logic [30:0] rad,
                                          logic [31:0] vx, logic [31:0] vy,
                                          logic [17:0] bbx, logic [17:0] bby);
    circle_t c;
    c.cx = cx; c.cy = cy; c.rad = rad; c.vx = vx; c.vy = vy; c.bbx = bbx; c.bby = bby;
    return c;
  endfunction

  // one run of random circles with the sender paused once halfway
  task automatic random_phase(int n);
    for (int i = 0; i < n / 2; i++) pending_circles.push_back(random_circle());
    while (pending_circles.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    hold_sender = 1'b1;
    while (expected_bounces.size() > 0) @(posedge clk_i);
    hold_sender = 1'b0;
    for (int i = n / 2; i < n; i++) pending_circles.push_back(random_circle());
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_SEG_START_X;
    cfg_wdata_i = '0;
    req_taken = 1'b0;
    hold_sender = 1'b0;
    errors = 0;
    cycles = 0;
    send_idle_pct = 24;
    recv_idle_pct = 77;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset segment from (0,0) to (1,0)
    pending_circles.push_back(make_circle(32'h8000, 32'h4000, 31'h8000, 32'h0, 32'hffff0000,
                                          18'h10000, 18'h10000));
    pending_circles.push_back(make_circle(32'h8000, 32'h0, 31'h100, 32'h10000, 32'h10000,
                                          18'h10000, 18'h10000)); // center on segment
    pending_circles.push_back(make_circle(32'h8000, 32'h0, 31'h0, 32'h10000, 32'h10000,
                                          18'h10000, 18'h10000)); // zero radius
    pending_circles.push_back(make_circle(32'hffff8000, 32'h1000, 31'h10000, 32'h10000,
                                          32'h0, 18'h20000, 18'h20000)); // before start
    pending_circles.push_back(make_circle(32'h18000, 32'hffff0000, 31'h18000, 32'h7fffffff,
                                          32'h80000000, 18'h3ffff, 18'h3ffff)); // past end
    pending_circles.push_back(make_circle(32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
                                          32'h80000000, 32'h80000000, 18'h3ffff, 18'h0));
    pending_circles.push_back(make_circle(32'h80000000, 32'h80000000, 31'h7fffffff,
                                          32'h7fffffff, 32'h7fffffff, 18'h0, 18'h3ffff));
    pending_circles.push_back(make_circle(32'h0, 32'h0, 31'h10, 32'h1234, 32'h5678,
                                          18'h10000, 18'h10000)); // on the start point
    pending_circles.push_back(make_circle(32'h10000, 32'h0, 31'h10, 32'h1234, 32'h5678,
                                          18'h10000, 18'h10000)); // on the end point
    pending_circles.push_back(make_circle(32'h8000, 32'h8000, 31'h8000, 32'h0, 32'h10000,
                                          18'h10000, 18'h10000)); // just touching, no hit
    wait_drained();
    random_phase(320);

    // wide diagonal segment at the coordinate extremes, maximum bounce on the x axis
    set_segment(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h3ffff, 32'h20000);
    random_phase(320);

    // zero-length segment
    send_idle_pct = 77;
    recv_idle_pct = 24;
    set_segment(32'h00123456, 32'hfff00000, 32'h00123456, 32'hfff00000, 32'h10000, 32'h8000);
    pending_circles.push_back(make_circle(32'h00123456, 32'hfff00000, 31'h5, 32'h10000,
                                          32'h10000, 18'h10000, 18'h10000));
    random_phase(300);

    // moderate random segment, zero bounce on one axis
    set_segment($signed($urandom) >>> 8, $signed($urandom) >>> 8,
                $signed($urandom) >>> 8, $signed($urandom) >>> 8, 32'h0, 32'h1c000);
    random_phase(320);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_segment(32'hfff80000, 32'h00050000, 32'h00030000, 32'hfffe0000, 32'h20000, 32'h0);
    random_phase(320);
    set_segment($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 131072),
                $urandom_range(0, 131072));
    random_phase(320);

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_circle_segment_bounce_unit: done, clean");
    end else begin
      $display("tb_circle_segment_bounce_unit: done, errors");
    end
    $finish;
  end

endmodule
